>>> src/sctpc_pkg.sv
package sctpc_pkg;

   // geometry
   localparam int NUM_SETS    = 128;
   localparam int NUM_WAYS    = 8;
   localparam int LINE_BYTES  = 32;
   localparam int ADDR_BITS   = 32;
   localparam int OFFSET_BITS = $clog2(LINE_BYTES);
   localparam int SET_BITS    = $clog2(NUM_SETS);
   localparam int WAY_BITS    = $clog2(NUM_WAYS);
   localparam int TAG_BITS    = ADDR_BITS - SET_BITS - OFFSET_BITS;
   localparam int PLRU_BITS   = NUM_WAYS - 1;
   localparam int PROC_BITS   = 3;

   // command queue depth between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // action codes
   localparam logic [1:0] ACT_READ   = 2'd0;
   localparam logic [1:0] ACT_WRITE  = 2'd1;
   localparam logic [1:0] ACT_SNOOP  = 2'd2;

   // snooped request kinds
   localparam logic [1:0] SNP_NONE  = 2'd0;
   localparam logic [1:0] SNP_READ  = 2'd1;
   localparam logic [1:0] SNP_WRITE = 2'd2;
   localparam logic [1:0] SNP_RDX   = 2'd3;

   // bus request codes
   localparam logic [1:0] BUS_NONE  = 2'd0;
   localparam logic [1:0] BUS_READ  = 2'd1;
   localparam logic [1:0] BUS_RDX   = 2'd2;
   localparam logic [1:0] BUS_WRITE = 2'd3;

   typedef enum logic [1:0] {
      OP_NOP,
      OP_READ,
      OP_WRITE,
      OP_INVAL
   } op_type;

   typedef struct packed {
      logic [1:0]           action;
      logic [ADDR_BITS-1:0] address;
      logic [1:0]           snoop_kind;
      logic [PROC_BITS-1:0] source_processor;
   } req_type;

   typedef struct packed {
      logic                hit;
      logic [WAY_BITS-1:0] way;
      logic [1:0]          bus_request;
      logic                invalidated;
   } rsp_type;

   typedef struct packed {
      op_type              op;
      logic [SET_BITS-1:0] set_idx;
      logic [TAG_BITS-1:0] tag;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   // one tag ram row: whole set
   typedef struct packed {
      logic [NUM_WAYS-1:0]               valid;
      logic [PLRU_BITS-1:0]              plru;
      logic [NUM_WAYS-1:0][TAG_BITS-1:0] tags;
   } row_type;

   // per-way masks that point the tree away from the touched way
   localparam logic [PLRU_BITS-1:0] TOUCH_OR [NUM_WAYS] = '{
      7'd11, 7'd3, 7'd17, 7'd1, 7'd36, 7'd4, 7'd64, 7'd0
   };
   localparam logic [PLRU_BITS-1:0] TOUCH_AND [NUM_WAYS] = '{
      7'd127, 7'd119, 7'd125, 7'd109, 7'd126, 7'd94, 7'd122, 7'd58
   };

   function automatic logic [PLRU_BITS-1:0] plru_touch(
      input logic [PLRU_BITS-1:0] t,
      input logic [WAY_BITS-1:0]  w
   );
      return (t | TOUCH_OR[w]) & TOUCH_AND[w];
   endfunction

   function automatic logic [WAY_BITS-1:0] plru_victim(input logic [PLRU_BITS-1:0] t);
      logic [WAY_BITS-1:0] v;
      v[2] = t[0];
      if (!t[0]) begin
         v[1] = t[1];
         v[0] = t[1] ? t[4] : t[3];
      end else begin
         v[1] = t[2];
         v[0] = t[2] ? t[6] : t[5];
      end
      return v;
   endfunction

endpackage

>>> src/sctpc_front.sv
module sctpc_front
   import sctpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [PROC_BITS-1:0] csr_wr_data,
   input  req_type              req_data,
   output cmd_type              cmd
);

   logic [PROC_BITS-1:0] own_id_ff;
   logic [PROC_BITS-1:0] own_id_in;

   assign own_id_in = csr_wr_en ? csr_wr_data : own_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= '0;
      end else begin
         own_id_ff <= own_id_in;
      end
   end

   // classify the beat into the operation the back end performs
   always_comb begin
      cmd.set_idx = req_data.address[OFFSET_BITS +: SET_BITS];
      cmd.tag     = req_data.address[OFFSET_BITS+SET_BITS +: TAG_BITS];
      case (req_data.action)
         ACT_READ:  cmd.op = OP_READ;
         ACT_WRITE: cmd.op = OP_WRITE;
         ACT_SNOOP: begin
            if ((req_data.snoop_kind inside {SNP_WRITE, SNP_RDX})
                  && (req_data.source_processor != own_id_ff)) begin
               cmd.op = OP_INVAL;
            end else begin
               cmd.op = OP_NOP;
            end
         end
         default:   cmd.op = OP_NOP;
      endcase
   end

endmodule

>>> src/sctpc_queue.sv
module sctpc_queue
   import sctpc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  cmd_type  push_cmd,
   output logic     full,
   input  logic     pop_en,
   output head_type head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   assign push = push_valid && !full;
   assign pop  = pop_en && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> src/sctpc_back.sv
module sctpc_back
   import sctpc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  head_type head,
   output logic     pop_en,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   row_type             tag_ram [NUM_SETS];
   row_type             row_ff;
   logic [NUM_SETS-1:0] row_init_ff, row_init_in;
   logic                row_ok_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                slot_free;
   logic                exec_go;
   logic [NUM_WAYS-1:0] valid_eff;
   logic [PLRU_BITS-1:0] plru_eff;
   logic [NUM_WAYS-1:0] match;
   logic                hit;
   logic [WAY_BITS-1:0] hit_way;
   logic                any_free;
   logic [WAY_BITS-1:0] free_way;
   logic [WAY_BITS-1:0] sel_way;
   row_type             row_new;
   logic                do_write;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pop_en    = (state_ff == ST_IDLE);
   assign exec_go   = (state_ff == ST_EXEC) && slot_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a row never written since reset reads as all invalid with a cleared tree
   assign valid_eff = row_ok_ff ? row_ff.valid : '0;
   assign plru_eff  = row_ok_ff ? row_ff.plru : '0;

   always_comb begin
      hit_way  = '0;
      free_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         match[w] = valid_eff[w] && (row_ff.tags[w] == cmd_ff.tag);
         if (match[w]) begin
            hit_way = WAY_BITS'(w);
         end
         if (!valid_eff[w]) begin
            free_way = WAY_BITS'(w);
         end
      end
      hit      = |match;
      any_free = !(&valid_eff);
      if (hit) begin
         sel_way = hit_way;
      end else if (any_free) begin
         sel_way = free_way;
      end else begin
         sel_way = plru_victim(plru_eff);
      end
   end

   always_comb begin
      row_new       = row_ff;
      row_new.valid = valid_eff;
      row_new.plru  = plru_eff;
      rsp_data_in   = '0;
      do_write      = 1'b0;
      case (cmd_ff.op)
         OP_READ, OP_WRITE: begin
            do_write = 1'b1;
            if (!hit) begin
               row_new.tags[sel_way]  = cmd_ff.tag;
               row_new.valid[sel_way] = 1'b1;
            end
            row_new.plru         = plru_touch(plru_eff, sel_way);
            rsp_data_in.hit      = hit;
            rsp_data_in.way      = sel_way;
            if (cmd_ff.op == OP_READ) begin
               rsp_data_in.bus_request = hit ? BUS_NONE : BUS_READ;
            end else begin
               rsp_data_in.bus_request = hit ? BUS_WRITE : BUS_RDX;
            end
         end
         OP_INVAL: begin
            do_write                = 1'b1;
            row_new.valid           = valid_eff & ~match;
            rsp_data_in.invalidated = hit;
         end
         default: begin
            do_write = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      row_init_in  = row_init_ff;
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               cmd_in   = head.cmd;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (do_write) begin
                  row_init_in[cmd_ff.set_idx] = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_init_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_init_ff  <= row_init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      if (exec_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // tag ram: read when a command is taken, written back at the end of exec
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && head.valid) begin
         row_ff    <= tag_ram[head.cmd.set_idx];
         row_ok_ff <= row_init_ff[head.cmd.set_idx];
      end
      if (exec_go && do_write) begin
         tag_ram[cmd_ff.set_idx] <= row_new;
      end
   end

endmodule

>>> src/snooping_cache_tag_plru_controller_top.sv
// tag and valid controller for an 8-way, 128-set write-invalidate cache with 32-byte lines
// and a 7-bit tree pseudo-lru per set. each request beat is a processor read, a processor
// write or a snooped bus request; each gives exactly one response beat, in order. a
// processor access reports hit and way, fills the lowest invalid way or the plru victim on
// a miss, and names the bus request to issue. a snooped write or read-exclusive from
// another processor invalidates every matching line. the front end takes a beat in any
// cycle its two-entry command queue has room; the back end works on one beat at a time: it
// reads the set's row from the single-port tag ram, then updates it and writes it back once
// the response slot is free, and only then takes the next beat. lines start invalid right
// out of reset (a per-set flag marks rows never written), so there is no clearing pass. csr
// writes of the own processor id are meant to happen while the block is idle.
module snooping_cache_tag_plru_controller_top
   import sctpc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,

   // configuration
   input  logic                 csr_wr_en,
   input  logic [PROC_BITS-1:0] csr_wr_data,

   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,

   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data
);

   cmd_type  front_cmd;   // classified request beat
   logic     queue_full;
   logic     pop_en;
   head_type queue_head;

   // stall while the command queue is full; the back end drains it on its own
   assign req_stall = queue_full;

   // front: snoop filter against own id, address split
   sctpc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (front_cmd)
   );

   // queue decouples request acceptance from the tag ram sequencing
   sctpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_cmd   (front_cmd),
      .full       (queue_full),
      .pop_en     (pop_en),
      .head       (queue_head)
   );

   // back: tag ram read-modify-write, plru update, response register
   sctpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (queue_head),
      .pop_en    (pop_en),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
